/* hdl/olst_pkg.sv */
package olst_pkg;

  // Default list depth.
  localparam int DEPTH_DEF = 64;

  // Field widths.
  localparam int ACT_W  = 2;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 7;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic load;   // write the tail cell
    logic start;  // clear the sweep wave
    logic step;   // advance the sweep wave one cell
    logic shift;  // close the gap behind the matched cell
  } olst_ctl_t;

endpackage

/* hdl/olst_req_if.sv */
interface olst_req_if;
  import olst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] item_value;
  logic [POS_W-1:0]        position;

  modport source (output valid, action, item_value, position, input ready);
  modport sink (input valid, action, item_value, position, output ready);
endinterface

/* hdl/olst_rsp_if.sv */
interface olst_rsp_if;
  import olst_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] read_value;
  logic [ECNT_W-1:0]       entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink (input valid, status, read_value, entry_count, output ready);
endinterface

/* hdl/olst_cell.sv */
module olst_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  olst_pkg::olst_ctl_t        ctl,
  input  logic [CW-1:0]              count,
  input  logic [olst_pkg::VAL_W-1:0] wdata,
  input  logic [olst_pkg::VAL_W-1:0] key,
  input  logic [olst_pkg::POS_W-1:0] pos,
  input  logic                       prev_sh,
  input  logic [olst_pkg::VAL_W-1:0] prev_rd,
  input  logic [olst_pkg::VAL_W-1:0] next_data,
  output logic [olst_pkg::VAL_W-1:0] data,
  output logic                       sh,
  output logic [olst_pkg::VAL_W-1:0] rd
);
  import olst_pkg::*;

  logic live;
  logic at_tail;
  logic at_pos;
  logic hit;

  // Position of this cell relative to the list.
  assign live    = 32'(count) > 32'(IDX);
  assign at_tail = 32'(count) == 32'(IDX);
  assign at_pos  = 32'(pos) == 32'(IDX);
  assign hit     = live && (data == key);

  // Stored entry: written when it is the tail, or pulled forward from the next cell.
  always_ff @(posedge clk) begin
    if (ctl.load && at_tail) begin
      data <= wdata;
    end else if (ctl.shift && sh) begin
      data <= next_data;
    end
  end

  // Match wave: once a match is seen, the matching cell and every later cell are marked.
  always_ff @(posedge clk) begin
    if (rst) begin
      sh <= 1'b0;
    end else if (ctl.start) begin
      sh <= 1'b0;
    end else if (ctl.step) begin
      sh <= prev_sh | hit;
    end
  end

  // Read wave: the addressed entry is carried toward the last cell.
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      rd <= at_pos ? data : prev_rd;
    end
  end

endmodule

/* hdl/ordered_list_append_remove_by_key_core.sv */
// Ordered list of up to DEPTH signed 32-bit entries kept in insertion order in a
// row of cells. An append request writes the tail cell, or reports full when the
// list holds DEPTH entries; it completes on acceptance, as do a read beyond the
// current count and the unused action code. A remove request and an in-range
// read start a wave that walks down the cell row one cell per clock: it marks
// every cell at or after the first match and carries the addressed entry toward
// the last cell. Such a request sweeps the whole row in SWEEP and gives its
// result in FINISH, where a remove that found its key closes the gap by having
// every marked cell take its neighbor's entry. One result is registered toward
// the output, and one more can wait behind it, so a new request is taken while
// a finished result has not yet been collected. Entries come out of reset
// undefined; the count and control are cleared, so no clearing pass is needed.
module ordered_list_append_remove_by_key_core #(
  parameter int DEPTH = olst_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  olst_req_if.sink   req,
  olst_rsp_if.source rsp
);
  import olst_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {IDLE, SWEEP, FINISH} state_t;

  state_t           state;
  state_t           state_next;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;
  logic [CW-1:0]    sweep_cnt;
  logic [VAL_W-1:0] key;
  logic [POS_W-1:0] pos;
  logic             is_remove;

  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [VAL_W-1:0]  out_value;
  logic [ECNT_W-1:0] out_count;
  logic              pend_valid;
  logic [STAT_W-1:0] pend_status;
  logic [VAL_W-1:0]  pend_value;
  logic [ECNT_W-1:0] pend_count;

  olst_ctl_t         ctl;
  logic              accept;
  logic              out_free;
  logic              done;
  logic [STAT_W-1:0] done_status;
  logic [VAL_W-1:0]  done_value;
  logic              found;

  logic [VAL_W-1:0] cell_data [DEPTH];
  logic [VAL_W-1:0] cell_rd [DEPTH];
  logic [DEPTH-1:0] cell_sh;

  // Handshakes.
  assign req.ready = (state == IDLE) && !pend_valid;
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign found     = cell_sh[DEPTH-1];

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.read_value  = out_value;
  assign rsp.entry_count = out_count;

  // Row of cells.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic             prev_sh;
    logic [VAL_W-1:0] prev_rd;
    logic [VAL_W-1:0] next_data;

    if (g == 0) begin : g_head
      assign prev_sh = 1'b0;
      assign prev_rd = '0;
    end else begin : g_body
      assign prev_sh = cell_sh[g-1];
      assign prev_rd = cell_rd[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign next_data = cell_data[g];
    end else begin : g_inner
      assign next_data = cell_data[g+1];
    end

    olst_cell #(
      .IDX (g),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .count     (count),
      .wdata     (req.item_value),
      .key       (key),
      .pos       (pos),
      .prev_sh   (prev_sh),
      .prev_rd   (prev_rd),
      .next_data (next_data),
      .data      (cell_data[g]),
      .sh        (cell_sh[g]),
      .rd        (cell_rd[g])
    );
  end

  // Sequencer: decode the request, run the sweep and produce the result.
  always_comb begin
    ctl         = '0;
    done        = 1'b0;
    done_status = ST_DONE;
    done_value  = '0;
    count_next  = count;
    state_next  = state;
    unique case (state)
      IDLE: begin
        if (accept) begin
          unique case (req.action)
            ACT_APPEND: begin
              done = 1'b1;
              if (32'(count) >= DEPTH) begin
                done_status = ST_FULL;
              end else begin
                ctl.load   = 1'b1;
                count_next = count + CW'(1);
              end
            end
            ACT_REMOVE: begin
              ctl.start  = 1'b1;
              state_next = SWEEP;
            end
            ACT_READ: begin
              if (32'(req.position) >= 32'(count)) begin
                done        = 1'b1;
                done_status = ST_RANGE;
              end else begin
                ctl.start  = 1'b1;
                state_next = SWEEP;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      SWEEP: begin
        ctl.step = 1'b1;
        if (sweep_cnt == CW'(1)) begin
          state_next = FINISH;
        end
      end
      FINISH: begin
        done       = 1'b1;
        state_next = IDLE;
        if (is_remove) begin
          if (found) begin
            ctl.shift  = 1'b1;
            count_next = count - CW'(1);
          end else begin
            done_status = ST_MISS;
          end
        end else begin
          done_value = cell_rd[DEPTH-1];
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State, count and the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      sweep_cnt  <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;

      if (ctl.start) begin
        sweep_cnt <= CW'(DEPTH);
      end else if (ctl.step) begin
        sweep_cnt <= sweep_cnt - CW'(1);
      end

      // Output register: take a waiting result, else a new one, else retire the taken one.
      if (pend_valid && out_free) begin
        out_valid  <= 1'b1;
        out_status <= pend_status;
        out_value  <= pend_value;
        out_count  <= pend_count;
        pend_valid <= 1'b0;
      end else if (done && out_free) begin
        out_valid  <= 1'b1;
        out_status <= done_status;
        out_value  <= done_value;
        out_count  <= ECNT_W'(count_next);
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      // A new result waits behind an occupied output register.
      if (done && !out_free) begin
        pend_valid  <= 1'b1;
        pend_status <= done_status;
        pend_value  <= done_value;
        pend_count  <= ECNT_W'(count_next);
      end
    end
  end

  // Request fields kept for the sweep.
  always_ff @(posedge clk) begin
    if (accept) begin
      key       <= req.item_value;
      pos       <= req.position;
      is_remove <= (req.action == ACT_REMOVE);
    end
  end

  // The list never holds more than DEPTH entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count exceeds depth");

  // A waiting result always sits behind an occupied output register.
  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("pending result with empty output register");

  // An accepted append into a list with room grows it by one.
  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && req.action == ACT_APPEND && 32'(count) < DEPTH)
      |=> count == $past(count) + CW'(1))
    else $error("append did not grow the list");

  // A remove that finds its key shrinks the list by one.
  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == FINISH && is_remove && found) |=> count == $past(count) - CW'(1))
    else $error("remove did not shrink the list");

endmodule

/* bench/tb.sv */
module tb;
  import olst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1700;
  localparam int MAX_WAIT = 18;
  localparam int CALM_FIRST = 300;
  localparam int CALM_LAST = 420;
  localparam int LONG_HOLD_AT = 700;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_AT = 1100;
  localparam int TAIL_CYCLES = DEPTH + 8;
  localparam int CYCLE_LIMIT = 1_000_000;

  // Action code that the package leaves unnamed; the block treats it as a no-op.
  localparam logic [ACT_W-1:0] ACT_IDLE = 2'd3;

  typedef enum int {PH_FILL, PH_CHURN, PH_DRAIN, PH_DUP} phase_e;

  typedef struct {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] item_value;
    logic [POS_W-1:0]        position;
    bit                      wait_idle;
  } list_req_t;

  typedef struct {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [ECNT_W-1:0]       entry_count;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst;

  olst_req_if req_ch ();
  olst_rsp_if rsp_ch ();

  ordered_list_append_remove_by_key_core #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Requests waiting to be offered, and results the list is expected to return.
  list_req_t pending_q [$];
  list_rsp_t result_q [$];

  // Mirror of the list contents, advanced as requests are accepted.
  logic signed [VAL_W-1:0] list_mem [DEPTH];
  int list_len = 0;

  // Contents as planned by the stimulus generator, used only to steer keys and positions.
  logic signed [VAL_W-1:0] plan_list [$];
  bit hold_next = 1'b0;

  int sent_count = 0;
  int recv_count = 0;
  int fail_count = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int cycle_count = 0;
  int n_append = 0, n_remove = 0, n_read = 0, n_idle = 0;
  int n_full = 0, n_miss = 0, n_range = 0, peak_len = 0;

  // Apply one accepted request to the mirror and return the result it must produce.
  function automatic list_rsp_t apply_request(list_req_t r);
    list_rsp_t res;
    int hit;
    int i;
    res.status = ST_DONE;
    res.read_value = '0;
    hit = -1;
    case (r.action)
      ACT_APPEND: begin
        n_append++;
        if (list_len >= DEPTH) begin
          res.status = ST_FULL;
          n_full++;
        end else begin
          list_mem[list_len] = r.item_value;
          list_len++;
        end
      end
      ACT_REMOVE: begin
        n_remove++;
        for (i = 0; i < list_len; i++) begin
          if (hit < 0 && list_mem[i] == r.item_value) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_MISS;
          n_miss++;
        end else begin
          for (i = hit; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      ACT_READ: begin
        n_read++;
        if (int'(r.position) >= list_len) begin
          res.status = ST_RANGE;
          n_range++;
        end else begin
          res.read_value = list_mem[r.position];
        end
      end
      default: n_idle++;
    endcase
    if (list_len > peak_len) peak_len = list_len;
    res.entry_count = ECNT_W'(list_len);
    return res;
  endfunction

  // Per-item wait: half the time none, otherwise up to MAX_WAIT; none inside the calm window.
  function automatic int draw_wait(int n);
    if (n >= CALM_FIRST && n < CALM_LAST) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, MAX_WAIT);
  endfunction

  // Queue a request and keep the planned contents in step with it.
  task automatic queue_req(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val,
                           input logic [POS_W-1:0] pos);
    list_req_t r;
    int i;
    r.action = act;
    r.item_value = val;
    r.position = pos;
    r.wait_idle = hold_next;
    hold_next = 1'b0;
    pending_q.push_back(r);
    if (act == ACT_APPEND && plan_list.size() < DEPTH) begin
      plan_list.push_back(val);
    end else if (act == ACT_REMOVE) begin
      for (i = 0; i < plan_list.size(); i++) begin
        if (plan_list[i] == val) begin
          plan_list.delete(i);
          break;
        end
      end
    end
  endtask

  // Values: fully random, or drawn from a small pool so that duplicates are common.
  function automatic logic signed [VAL_W-1:0] pick_value(bit dup_mode);
    if (!dup_mode) return $urandom();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return -32'sd1;
      3: return 32'sd0;
      4: return 32'sd1;
      default: return 32'sd42;
    endcase
  endfunction

  // Keys: mostly one that is held, sometimes any value.
  function automatic logic signed [VAL_W-1:0] pick_key(bit dup_mode);
    if (plan_list.size() > 0 && $urandom_range(0, 4) != 0)
      return plan_list[$urandom_range(0, plan_list.size() - 1)];
    return pick_value(dup_mode);
  endfunction

  // Positions: mostly inside the list, sometimes anywhere.
  function automatic logic [POS_W-1:0] pick_pos();
    if (plan_list.size() > 0 && $urandom_range(0, 3) != 0)
      return POS_W'($urandom_range(0, plan_list.size() - 1));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  // One phase of random traffic of the given kind.
  task automatic gen_phase(input phase_e kind);
    int n;
    int pick;
    bit dup;
    dup = 1'($urandom_range(0, 1));
    case (kind)
      PH_FILL: begin
        while (plan_list.size() < DEPTH) begin
          if ($urandom_range(0, 4) == 0) queue_req(ACT_READ, $urandom(), pick_pos());
          else queue_req(ACT_APPEND, pick_value(dup), POS_W'($urandom()));
        end
        repeat ($urandom_range(1, 3))
          queue_req(ACT_APPEND, pick_value(dup), POS_W'($urandom()));
        queue_req(ACT_READ, $urandom(), POS_W'(DEPTH - 1));
        queue_req(ACT_READ, $urandom(), '0);
      end
      PH_DRAIN: begin
        while (plan_list.size() > 0) begin
          pick = $urandom_range(0, 5);
          if (pick == 0) queue_req(ACT_REMOVE, pick_value(dup), POS_W'($urandom()));
          else if (pick == 1) queue_req(ACT_READ, $urandom(), pick_pos());
          else queue_req(ACT_REMOVE, plan_list[$urandom_range(0, plan_list.size() - 1)],
                         POS_W'($urandom()));
        end
        queue_req(ACT_READ, $urandom(), pick_pos());
        queue_req(ACT_REMOVE, pick_value(dup), POS_W'($urandom()));
      end
      default: begin
        if (kind == PH_DUP) dup = 1'b1;
        n = $urandom_range(40, 150);
        repeat (n) begin
          pick = $urandom_range(0, 19);
          if (pick < 8) queue_req(ACT_APPEND, pick_value(dup), POS_W'($urandom()));
          else if (pick < 15) queue_req(ACT_REMOVE, pick_key(dup), POS_W'($urandom()));
          else if (pick < 19) queue_req(ACT_READ, $urandom(), pick_pos());
          else queue_req(ACT_IDLE, $urandom(), POS_W'($urandom()));
        end
      end
    endcase
  endtask

  // Driver: offers the head of the pending queue, holding it until the list takes it.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        result_q.push_back(apply_request(pending_q.pop_front()));
        sent_count++;
        send_wait = draw_wait(sent_count);
      end
      if (req_ch.valid && !req_ch.ready) begin
        // Keep the current request on the bus.
      end else if (send_wait > 0) begin
        send_wait--;
        req_ch.valid <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   (!pending_q[0].wait_idle || result_q.size() == 0)) begin
        req_ch.valid <= 1'b1;
        req_ch.action <= pending_q[0].action;
        req_ch.item_value <= pending_q[0].item_value;
        req_ch.position <= pending_q[0].position;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: takes results with random back-pressure and checks them in order.
  always @(posedge clk) begin
    list_rsp_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: status %0d read_value %0h entry_count %0d",
                 rsp_ch.status, rsp_ch.read_value, rsp_ch.entry_count);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            fail_count++;
          end
          if (rsp_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0h, got %0h", want.read_value, rsp_ch.read_value);
            fail_count++;
          end
          if (rsp_ch.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   rsp_ch.entry_count);
            fail_count++;
          end
        end
        recv_count++;
        recv_wait = (recv_count == LONG_HOLD_AT) ? LONG_HOLD : draw_wait(recv_count);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               result_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stimulus
    int directed_end;
    phase_e kind;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_APPEND;
    req_ch.item_value = '0;
    req_ch.position = '0;
    rsp_ch.ready = 1'b0;

    // Directed: empty list, extreme values, duplicates, tail removal, misses, idle code.
    queue_req(ACT_READ, 32'sd0, '0);
    queue_req(ACT_REMOVE, 32'sd0, '0);
    queue_req(ACT_IDLE, -32'sd1, '1);
    queue_req(ACT_APPEND, 32'sh7FFF_FFFF, '0);
    queue_req(ACT_APPEND, 32'sh8000_0000, '1);
    queue_req(ACT_APPEND, -32'sd1, '0);
    queue_req(ACT_APPEND, 32'sd0, '0);
    queue_req(ACT_APPEND, 32'sh8000_0000, '0);
    queue_req(ACT_READ, 32'sd0, POS_W'(0));
    queue_req(ACT_READ, 32'sd0, POS_W'(4));
    queue_req(ACT_READ, 32'sd0, POS_W'(5));
    queue_req(ACT_READ, -32'sd1, '1);
    queue_req(ACT_REMOVE, 32'sh8000_0000, '0);
    queue_req(ACT_READ, 32'sd0, POS_W'(1));
    queue_req(ACT_READ, 32'sd0, POS_W'(3));
    queue_req(ACT_REMOVE, 32'sh8000_0000, '0);
    queue_req(ACT_APPEND, 32'sd5, '0);
    queue_req(ACT_READ, 32'sd0, POS_W'(3));
    queue_req(ACT_REMOVE, 32'sd12345, '0);
    queue_req(ACT_REMOVE, 32'sh7FFF_FFFF, '0);
    queue_req(ACT_READ, 32'sd0, POS_W'(0));
    queue_req(ACT_IDLE, 32'sd0, '0);
    directed_end = pending_q.size();

    // Random phases; the first fills the list and waits for the directed part to drain.
    hold_next = 1'b1;
    gen_phase(PH_FILL);
    while (pending_q.size() < directed_end + RANDOM_ITEMS) begin
      kind = phase_e'($urandom_range(0, 3));
      hold_next = ($urandom_range(0, 3) == 0);
      gen_phase(kind);
    end
    pending_q[DRAIN_AT].wait_idle = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0 || result_q.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d appends, %0d removes, %0d reads, %0d idle codes",
             sent_count, n_append, n_remove, n_read, n_idle);
    $display("Dropped on full %0d, keys missed %0d, reads out of range %0d, peak fill %0d",
             n_full, n_miss, n_range, peak_len);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
